@@ src/rorb_pkg.sv @@
package rorb_pkg;

  localparam int DEF_COMPONENT_BITS = 16;
  localparam int FIELD_W            = 48;
  localparam int N_IN_FIELDS        = 7;
  localparam int THR_W              = 14;
  localparam logic [THR_W-1:0] THR_RESET = 14'd16;
  localparam int DIR_SHIFT          = 14;  // threshold Q1.14 -> Q.28
  localparam int HALF_SHIFT         = 14;  // half size Q.8 -> Q.22
  localparam int QBITS              = 32;  // Q16.16 distance
  localparam int INT_BITS           = 10;  // quotient integer bits before saturation
  localparam int OUT_TDATA_W        = 40;

  // per-axis flags that ride along with the divider
  typedef struct packed {
    logic par;     // direction projection within threshold
    logic pmiss;   // parallel slab does not contain origin
    logic neg_lo;  // sign of (p - h) / d
    logic neg_hi;  // sign of (p + h) / d
  } axis_ctx_t;

endpackage

@@ src/ray_oriented_box_slab_test_unit.sv @@
// Ray versus oriented box slab test. Each s_axis transaction carries one ray
// (origin, direction) and one box (center, three local axes, half sizes);
// each m_axis transaction returns the hit flag and the Q16.16 entry distance
// (0 on a miss or when the origin already lies inside). One test is taken
// every cycle unless backpressure stalls the pipeline. The datapath runs
// through four front stages (offset, products, dot sums, slab numerators),
// the six per-axis slab dividers, each a 33-register pipeline (an input
// capture and 32 one-bit quotient steps), two fold stages and the output
// register. Backpressure stalls the whole pipeline through a one-entry skid
// stage, so no transaction is lost or repeated. The parallel threshold
// register is written through the cfg port; the user must write it only
// while the unit is idle, which the block itself does not enforce. It
// resets to 16 (Q1.14).
module ray_oriented_box_slab_test_unit import rorb_pkg::*; #(
  parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // ray_origin, ray_direction, box_center, box_axis_x, box_axis_y,
  // box_axis_z, box_half_sizes (48 bits each, from bit 0 up)
  input  logic [N_IN_FIELDS*FIELD_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit [0], entry_distance [32:1], zero [39:33]
  output logic [OUT_TDATA_W-1:0]         m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [THR_W-1:0]               cfg_data_i
);

  localparam int C     = COMPONENT_BITS;
  localparam int XW    = (3 * C > FIELD_W) ? 3 * C : FIELD_W;
  localparam int OW    = C + 1;          // center - origin
  localparam int PRW   = 2 * C + 1;      // axis * offset
  localparam int DRW   = 2 * C;          // axis * direction
  localparam int PW    = 2 * C + 3;      // projected offset
  localparam int DSW   = 2 * C + 2;      // projected direction
  localparam int HW    = C + HALF_SHIFT; // half size in Q.22
  localparam int NW    = 2 * C + 4;      // slab numerator
  localparam int DW    = 2 * C + 2;      // |d|
  localparam int MW    = (DW > THR_W + DIR_SHIFT) ? DW : THR_W + DIR_SHIFT;
  localparam int TW    = QBITS + 1;      // signed saturated distance
  localparam int DEPTH = QBITS + 1;      // divider register stages

  localparam logic signed [TW-1:0] T_MAX = TW'({1'b0, {QBITS{1'b1}}});

  // ---------------- configuration ----------------
  logic [THR_W-1:0] thr_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---------------- stall control ----------------
  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // ---------------- field unpack ----------------
  logic [XW-1:0] fx [N_IN_FIELDS];
  for (genvar j = 0; j < N_IN_FIELDS; j++) begin : g_field
    assign fx[j] = XW'(s_axis_tdata[j*FIELD_W +: FIELD_W]);
  end

  // ---------------- stage 1: offset, capture ----------------
  logic signed [OW-1:0] off_d [3];
  logic signed [OW-1:0] off_q [3];
  logic signed [C-1:0]  dir_q [3];
  logic signed [C-1:0]  ax_q  [3][3];
  logic [C-1:0]         half1_q [3];
  logic                 v1_q;

  for (genvar k = 0; k < 3; k++) begin : g_off
    assign off_d[k] = $signed(OW'($signed(fx[2][k*C +: C])))
                    - $signed(OW'($signed(fx[0][k*C +: C])));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        off_q[k]   <= off_d[k];
        dir_q[k]   <= $signed(fx[1][k*C +: C]);
        half1_q[k] <= fx[6][k*C +: C];
        for (int i = 0; i < 3; i++) begin
          ax_q[i][k] <= $signed(fx[3+i][k*C +: C]);
        end
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PRW-1:0] pp_q [3][3];
  logic signed [DRW-1:0] dp_q [3][3];
  logic [C-1:0]          half2_q [3];
  logic                  v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        half2_q[i] <= half1_q[i];
        for (int k = 0; k < 3; k++) begin
          pp_q[i][k] <= PRW'(ax_q[i][k]) * PRW'(off_q[k]);
          dp_q[i][k] <= DRW'(ax_q[i][k]) * DRW'(dir_q[k]);
        end
      end
    end
  end

  // ---------------- stage 3: dot sums ----------------
  logic signed [PW-1:0]  p_q [3];
  logic signed [DSW-1:0] d_q [3];
  logic [C-1:0]          half3_q [3];
  logic                  v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        half3_q[i] <= half2_q[i];
        p_q[i] <= PW'(pp_q[i][0]) + PW'(pp_q[i][1]) + PW'(pp_q[i][2]);
        d_q[i] <= DSW'(dp_q[i][0]) + DSW'(dp_q[i][1]) + DSW'(dp_q[i][2]);
      end
    end
  end

  // ---------------- stage 4: slab numerators, parallel test ----------------
  logic [NW-1:0] nlo_abs_d [3];
  logic [NW-1:0] nhi_abs_d [3];
  logic [DW-1:0] dabs_d    [3];
  axis_ctx_t     ctx_d     [3];

  for (genvar i = 0; i < 3; i++) begin : g_slab
    logic [HW-1:0]        h;
    logic signed [NW-1:0] hs;
    logic signed [NW-1:0] pe;
    logic signed [NW-1:0] nlo;
    logic signed [NW-1:0] nhi;
    logic                 dneg;
    logic                 par;
    assign h    = HW'(half3_q[i]) << HALF_SHIFT;
    assign hs   = $signed(NW'(h));
    assign pe   = NW'(p_q[i]);
    assign nlo  = pe - hs;
    assign nhi  = pe + hs;
    assign dneg = d_q[i][DSW-1];
    assign dabs_d[i]    = dneg ? DW'(-d_q[i]) : DW'(d_q[i]);
    assign nlo_abs_d[i] = nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
    assign nhi_abs_d[i] = nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
    assign par = !(MW'(dabs_d[i]) > (MW'(thr_q) << DIR_SHIFT));
    assign ctx_d[i].par    = par;
    assign ctx_d[i].pmiss  = par && ((pe > hs) || (pe < -hs));
    assign ctx_d[i].neg_lo = nlo[NW-1] ^ dneg;
    assign ctx_d[i].neg_hi = nhi[NW-1] ^ dneg;
  end

  logic [NW-1:0] nlo_abs_q [3];
  logic [NW-1:0] nhi_abs_q [3];
  logic [DW-1:0] dabs_q    [3];
  axis_ctx_t     ctx4_q    [3];
  logic          v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nlo_abs_q[i] <= nlo_abs_d[i];
        nhi_abs_q[i] <= nhi_abs_d[i];
        dabs_q[i]    <= dabs_d[i];
        ctx4_q[i]    <= ctx_d[i];
      end
    end
  end

  // ---------------- dividers ----------------
  logic [QBITS-1:0] mag_lo [3];
  logic [QBITS-1:0] mag_hi [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rorb_div #(.NW(NW), .DW(DW)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nlo_abs_q[i]),
      .den_i (dabs_q[i]),
      .quo_o (mag_lo[i])
    );
    rorb_div #(.NW(NW), .DW(DW)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nhi_abs_q[i]),
      .den_i (dabs_q[i]),
      .quo_o (mag_hi[i])
    );
  end

  // flags follow the divider pipeline
  axis_ctx_t ctxd_q [DEPTH][3];
  logic      vd_q   [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctxd_q[0] <= ctx4_q;
      for (int s = 1; s < DEPTH; s++) begin
        ctxd_q[s] <= ctxd_q[s-1];
      end
    end
  end

  // ---------------- fold stage 1: signed, ordered distances ----------------
  logic signed [TW-1:0] lo_d [3];
  logic signed [TW-1:0] hi_d [3];
  logic [2:0]           pm_d;

  for (genvar i = 0; i < 3; i++) begin : g_order
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    assign t1 = ctxd_q[DEPTH-1][i].neg_lo ? -$signed({1'b0, mag_lo[i]})
                                          :  $signed({1'b0, mag_lo[i]});
    assign t2 = ctxd_q[DEPTH-1][i].neg_hi ? -$signed({1'b0, mag_hi[i]})
                                          :  $signed({1'b0, mag_hi[i]});
    assign pm_d[i] = ctxd_q[DEPTH-1][i].pmiss;
    always_comb begin
      if (ctxd_q[DEPTH-1][i].par) begin
        lo_d[i] = '0;
        hi_d[i] = T_MAX;
      end else if (t1 > t2) begin
        lo_d[i] = t2;
        hi_d[i] = t1;
      end else begin
        lo_d[i] = t1;
        hi_d[i] = t2;
      end
    end
  end

  logic signed [TW-1:0] lo_q [3];
  logic signed [TW-1:0] hi_q [3];
  logic                 pm1_q;
  logic                 vf1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      pm1_q <= |pm_d;
    end
  end

  // ---------------- fold stage 2: partial max / min ----------------
  logic signed [TW-1:0] na_q, nb_q, fa_q, fb_q;
  logic                 pm2_q;
  logic                 vf2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q  <= (lo_q[0] > lo_q[1]) ? lo_q[0] : lo_q[1];
      nb_q  <= (lo_q[2] > 0) ? lo_q[2] : '0;
      fa_q  <= (hi_q[0] < hi_q[1]) ? hi_q[0] : hi_q[1];
      fb_q  <= hi_q[2];
      pm2_q <= pm1_q;
    end
  end

  // final compare feeds the output register
  logic signed [TW-1:0] near_max, far_min;
  logic                 miss;
  logic                 res_hit;
  logic [QBITS-1:0]     res_dist;

  assign near_max = (na_q > nb_q) ? na_q : nb_q;
  assign far_min  = (fa_q < fb_q) ? fa_q : fb_q;
  assign miss     = pm2_q || (far_min < near_max);
  assign res_hit  = !miss;
  assign res_dist = miss ? '0 : near_max[QBITS-1:0];

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      for (int s = 0; s < DEPTH; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vd_q[0] <= v4_q;
      for (int s = 1; s < DEPTH; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
      vf1_q <= vd_q[DEPTH-1];
      vf2_q <= vf1_q;
    end
  end

  // ---------------- output register and skid ----------------
  logic             out_v_q;
  logic             out_hit_q, skid_hit_q;
  logic [QBITS-1:0] out_dist_q, skid_dist_q;
  logic             push, take;

  assign push = en && vf2_q;
  assign take = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_hit_q  <= skid_hit_q;
        out_dist_q <= skid_dist_q;
      end
    end else if (push) begin
      if (out_v_q && !take) begin
        skid_hit_q  <= res_hit;
        skid_dist_q <= res_dist;
      end else begin
        out_hit_q  <= res_hit;
        out_dist_q <= res_dist;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_dist_q, out_hit_q});

endmodule

@@ src/rorb_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// quo = min(floor(num * 2^22 / den), 2^32 - 1)
module rorb_div import rorb_pkg::*; #(
  parameter int NW = 36,
  parameter int DW = 34
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QBITS-1:0] quo_o
);

  localparam int CW = (NW > DW + INT_BITS) ? NW : DW + INT_BITS;

  logic [DW-1:0]       r_q   [QBITS+1];
  logic [DW-1:0]       den_q [QBITS+1];
  logic [QBITS-1:0]    q_q   [QBITS+1];
  logic [INT_BITS-1:0] x_q   [QBITS+1];
  logic                ovf_q [QBITS+1];

  logic [DW-1:0]       r_nx [QBITS];
  logic [QBITS-1:0]    q_nx [QBITS];
  logic [INT_BITS-1:0] x_nx [QBITS];

  logic ovf_in;
  assign ovf_in = CW'(num_i) >= (CW'(den_i) << INT_BITS);

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        take;
    assign rs      = {r_q[k], x_q[k][INT_BITS-1]};
    assign diff    = rs - {1'b0, den_q[k]};
    assign take    = !diff[DW];
    assign r_nx[k] = take ? diff[DW-1:0] : rs[DW-1:0];
    assign q_nx[k] = {q_q[k][QBITS-2:0], take};
    assign x_nx[k] = x_q[k] << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= DW'(num_i >> INT_BITS);
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      x_q[0]   <= num_i[INT_BITS-1:0];
      ovf_q[0] <= ovf_in;
      for (int k = 0; k < QBITS; k++) begin
        r_q[k+1]   <= r_nx[k];
        den_q[k+1] <= den_q[k];
        q_q[k+1]   <= q_nx[k];
        x_q[k+1]   <= x_nx[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = ovf_q[QBITS] ? '1 : q_q[QBITS];

endmodule

@@ dv/tb.sv @@
module tb;
  import rorb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = DEF_COMPONENT_BITS;
  localparam int LATENCY   = 40;
  localparam int IN_W      = N_IN_FIELDS * FIELD_W;
  localparam longint DMAX  = 64'd4294967295;

  // one slab-test transaction as seen on the input stream
  typedef struct packed {
    logic [FIELD_W-1:0] half_sizes;
    logic [FIELD_W-1:0] axis_z;
    logic [FIELD_W-1:0] axis_y;
    logic [FIELD_W-1:0] axis_x;
    logic [FIELD_W-1:0] center;
    logic [FIELD_W-1:0] dir;
    logic [FIELD_W-1:0] origin;
  } ray_box_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
  } slab_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  ray_oriented_box_slab_test_unit #(.COMPONENT_BITS(CB)) dut (.*);

  // predictor copy of the threshold register
  logic [THR_W-1:0] thr_shadow = THR_RESET;
  slab_result_t hit_queue[$];
  int  n_errors = 0;
  bit  quiet_tail = 0;   // no idling on either side in the last part
  bit  rdy_random = 1;

  // ---------------------------------------------------------------- predictor
  function automatic longint comp_s(logic [FIELD_W-1:0] v, int i);
    logic [CB-1:0] c;
    c = v[i*CB +: CB];
    return longint'($signed(c));
  endfunction

  function automatic longint comp_u(logic [FIELD_W-1:0] v, int i);
    logic [CB-1:0] c;
    c = v[i*CB +: CB];
    return longint'({1'b0, c});
  endfunction

  // Q.22 over Q.28, truncated magnitude, saturated to 32 bits, then signed
  function automatic longint slab_quot(longint n, longint d);
    logic [127:0] un, ud, q;
    longint mag;
    bit neg;
    neg = (n < 0) != (d < 0);
    un  = 128'((n < 0) ? -n : n);
    ud  = 128'((d < 0) ? -d : d);
    q   = (un << 22) / ud;
    mag = (q > DMAX) ? DMAX : longint'(q);
    return neg ? -mag : mag;
  endfunction

  function automatic slab_result_t predict_slab(ray_box_t it);
    longint off[3], dv[3];
    longint near_max, far_min, thr, p, d, h, a, t1, t2, tmp;
    logic [FIELD_W-1:0] ax;
    bit miss;
    slab_result_t r;
    near_max = 0;
    far_min  = DMAX;
    thr      = longint'(thr_shadow) << 14;
    miss     = 0;
    for (int k = 0; k < 3; k++) begin
      off[k] = comp_s(it.center, k) - comp_s(it.origin, k);
      dv[k]  = comp_s(it.dir, k);
    end
    for (int i = 0; i < 3; i++) begin
      if (!miss) begin
        ax = (i == 0) ? it.axis_x : (i == 1) ? it.axis_y : it.axis_z;
        p = 0;
        d = 0;
        h = comp_u(it.half_sizes, i) << 14;
        for (int k = 0; k < 3; k++) begin
          a = comp_s(ax, k);
          p += a * off[k];
          d += a * dv[k];
        end
        if (((d < 0) ? -d : d) > thr) begin
          t1 = slab_quot(p - h, d);
          t2 = slab_quot(p + h, d);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > near_max) near_max = t1;
          if (t2 < far_min) far_min = t2;
          if (far_min < near_max) miss = 1;
        end else if (p < -h || p > h) begin
          miss = 1;
        end
      end
    end
    r.hit      = !miss;
    r.distance = miss ? 32'd0 : near_max[31:0];
    return r;
  endfunction

  // ----------------------------------------------------------------- drivers
  // tvalid stays high between back-to-back transactions; idle gaps and
  // drains drop it
  task automatic send_test(ray_box_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    hit_queue.insert(hit_queue.size(), predict_slab(it));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_shadow = v;
  endtask

  // receiver stall pattern: random bursts, none in the tail
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && rdy_random && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 5);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 8);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // result checker: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    slab_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        exp_r = hit_queue.pop_front();
        if (m_axis_tdata[0] !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, m_axis_tdata[0]);
          n_errors++;
        end
        if (m_axis_tdata[32:1] !== exp_r.distance) begin
          $display("%0t: entry_distance expected %h actual %h",
                   $time, exp_r.distance, m_axis_tdata[32:1]);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    logic [FIELD_W-1:0] v;
    v = '0;
    v[0 +: CB]    = CB'(x);
    v[CB +: CB]   = CB'(y);
    v[2*CB +: CB] = CB'(z);
    return v;
  endfunction

  localparam int ONE = 16384;  // 1.0 in Q1.14

  // axis-aligned box of half size hs at the given center, ray along +x from origin
  function automatic ray_box_t aligned_case(int ox, int cx, int hs);
    ray_box_t it;
    it.origin     = pack3(ox, 0, 0);
    it.dir        = pack3(ONE - 1, 0, 0);
    it.center     = pack3(cx, 0, 0);
    it.axis_x     = pack3(ONE - 1, 0, 0);
    it.axis_y     = pack3(0, ONE - 1, 0);
    it.axis_z     = pack3(0, 0, ONE - 1);
    it.half_sizes = pack3(hs, hs, hs);
    return it;
  endfunction

  function automatic ray_box_t random_case();
    ray_box_t it;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      // raw noise over every bit
      it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      // plausible geometry: small positions, random directions, jittered axes
      it.origin = pack3($signed($urandom_range(0, 8191)) - 4096,
                        $signed($urandom_range(0, 8191)) - 4096,
                        $signed($urandom_range(0, 8191)) - 4096);
      it.center = pack3($signed($urandom_range(0, 8191)) - 4096,
                        $signed($urandom_range(0, 8191)) - 4096,
                        $signed($urandom_range(0, 8191)) - 4096);
      it.dir    = pack3($signed($urandom_range(0, 32767)) - ONE,
                        $signed($urandom_range(0, 32767)) - ONE,
                        $signed($urandom_range(0, 32767)) - ONE);
      if (sel < 6) begin
        // aim the ray roughly at the box so hits are common
        it.dir = pack3(comp_s(it.center, 0) - comp_s(it.origin, 0),
                       comp_s(it.center, 1) - comp_s(it.origin, 1),
                       comp_s(it.center, 2) - comp_s(it.origin, 2));
      end
      it.axis_x = pack3(ONE - 1 - $urandom_range(0, 300), $urandom_range(0, 600) - 300,
                        $urandom_range(0, 600) - 300);
      it.axis_y = pack3($urandom_range(0, 600) - 300, ONE - 1 - $urandom_range(0, 300),
                        $urandom_range(0, 600) - 300);
      it.axis_z = pack3($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                        ONE - 1 - $urandom_range(0, 300));
      it.half_sizes = pack3($urandom_range(0, 2047), $urandom_range(0, 2047),
                            (sel == 9) ? $urandom_range(0, 65535) : $urandom_range(0, 2047));
    end
    return it;
  endfunction

  task automatic test_directed();
    ray_box_t it;
    send_test(aligned_case(0, 2560, 256));        // hit ahead
    send_test(aligned_case(0, 0, 256));           // origin inside
    send_test(aligned_case(2560, 0, 256));        // box behind
    it = aligned_case(0, 2560, 256);
    it.center = pack3(2560, 1024, 0);             // parallel slab misses
    send_test(it);
    it = aligned_case(0, 2560, 256);
    it.dir = '0;                                  // zero direction, inside test only
    send_test(it);
    it.origin = pack3(0, 0, 0);
    it.center = pack3(0, 0, 0);
    send_test(it);
    it = aligned_case(-32768, 32767, 65535);      // field extremes, huge half sizes
    send_test(it);
    it = aligned_case(0, 32767, 0);
    it.dir = pack3(1000, 0, 0);                   // small slope, long distance
    send_test(it);
    it.dir = pack3(-ONE, 0, 0);
    send_test(it);
    send_test('0);
    send_test('1);
    it = '1;
    it.half_sizes = '0;
    send_test(it);
    for (int i = 0; i < 8; i++) send_test(random_case());
  endtask

  task automatic test_threshold_sweep();
    logic [THR_W-1:0] thr_vals[4] = '{14'd0, 14'h3FFF, 14'd500, 14'd16};
    foreach (thr_vals[j]) begin
      drain_results();
      write_threshold(thr_vals[j]);
      for (int i = 0; i < 60; i++) send_test(random_case());
    end
  endtask

  task automatic test_random_stream();
    drain_results();  // sender waits for every result once
    write_threshold(THR_W'($urandom_range(0, 16383)));
    for (int i = 0; i < 800; i++) send_test(random_case());
    drain_results();
    write_threshold(THR_RESET);
    quiet_tail = 1;
    for (int i = 0; i < 250; i++) send_test(random_case());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_sweep();
    test_random_stream();
    drain_results();
    if (n_errors == 0 && hit_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
